// ----- src/tfd_pkg.sv -----
// shared types and constants of the tracking frame deframer
package tfd_pkg;

	localparam logic [1:0] CFG_MODE       = 2'd0;
	localparam logic [1:0] CFG_HDR_FIRST  = 2'd1;
	localparam logic [1:0] CFG_HDR_SECOND = 2'd2;
	localparam logic [1:0] CFG_FIXED_ID   = 2'd3;

	localparam logic [1:0] MODE_HDR_ONLY   = 2'd1;
	localparam logic [1:0] MODE_FIXED_ONLY = 2'd2;

	localparam logic [7:0] FIXED_ID_RESET  = 8'hD1;
	localparam int         FIXED_FRAME_LEN = 29;
	localparam logic [7:0] SUM_SEED        = 8'd64;

	localparam int FLAG_STATUS_BIT = 1;
	localparam int FLAG_ORIENT_BIT = 2;

	localparam int TDATA_W = 336;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] hdr_first;
		logic [7:0] hdr_second;
		logic [7:0] fixed_id;
	} cfg_t;

	typedef struct packed {
		logic        frame_kind;
		logic [63:0] pos_x;
		logic [63:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] roll;
		logic [31:0] pitch;
		logic [31:0] yaw;
		logic [31:0] time_ms;
		logic [31:0] flag_word;
		logic [7:0]  beacon_count;
		logic [7:0]  solution_type;
	} res_t;

endpackage

// ----- src/tfd_parser.sv -----
// frame hunt, field capture and result build, one byte per step
module tfd_parser #(
	parameter int MAX_FRAME_LEN = 512,
	parameter int MIN_FRAME_LEN = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    rx_byte,
	input  tfd_pkg::cfg_t cfg,
	output logic          hit,
	output tfd_pkg::res_t res
);
	import tfd_pkg::*;

	localparam int IdxW = $clog2(MAX_FRAME_LEN + 1);

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_HDR2   = 3'd1;
	localparam logic [2:0] PH_LEN_LO = 3'd2;
	localparam logic [2:0] PH_LEN_HI = 3'd3;
	localparam logic [2:0] PH_HBODY  = 3'd4;
	localparam logic [2:0] PH_FBODY  = 3'd5;

	logic [2:0]      phase_q, phase_d;
	logic [IdxW-1:0] idx_q, idx_d, idx_inc, obase, okey;
	logic [15:0]     len_q, len_d, len_new;
	logic [7:0]      sum_q, sum_d;
	logic [63:0]     wide_q [2];
	logic [63:0]     wide_d [2];
	logic [31:0]     narrow_q [6];
	logic [31:0]     narrow_d [6];
	logic [7:0]      stat_q [2];
	logic [7:0]      stat_d [2];
	logic            kind_fixed, has_s, has_o, flag_s;
	logic [5:0]      off_end;

	function automatic logic [31:0] sx32(input logic [31:0] v);
		return {{8{v[23]}}, v[23:0]};
	endfunction

	function automatic logic [63:0] sx64(input logic [31:0] v);
		return {{40{v[23]}}, v[23:0]};
	endfunction

	assign idx_inc = idx_q + 1'b1;
	assign len_new = {rx_byte, len_q[7:0]};
	assign flag_s  = narrow_q[0][FLAG_STATUS_BIT];
	assign obase   = flag_s ? IdxW'(36) : IdxW'(32);
	assign okey    = idx_q - obase;

	always_comb begin
		phase_d    = phase_q;
		idx_d      = idx_q;
		len_d      = len_q;
		sum_d      = sum_q;
		wide_d     = wide_q;
		narrow_d   = narrow_q;
		stat_d     = stat_q;
		hit        = 1'b0;
		kind_fixed = 1'b0;
		case (phase_q)
			PH_HDR2: begin
				if (rx_byte == cfg.hdr_second) begin
					idx_d   = IdxW'(2);
					phase_d = PH_LEN_LO;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_LEN_LO: begin
				len_d   = {8'h00, rx_byte};
				idx_d   = IdxW'(3);
				phase_d = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len_d = len_new;
				idx_d = IdxW'(4);
				if (len_new < 16'(MIN_FRAME_LEN) || len_new > 16'(MAX_FRAME_LEN))
					phase_d = PH_IDLE;
				else
					phase_d = PH_HBODY;
			end
			PH_HBODY: begin
				if (idx_q >= IdxW'(4) && idx_q < IdxW'(8)) begin
					narrow_d[0][8*idx_q[1:0] +: 8] = rx_byte;
				end else if (idx_q >= IdxW'(8) && idx_q < IdxW'(12)) begin
					narrow_d[1][8*idx_q[1:0] +: 8] = rx_byte;
				end else if (idx_q >= IdxW'(12) && idx_q < IdxW'(20)) begin
					wide_d[0][8*3'(idx_q - IdxW'(12)) +: 8] = rx_byte;
				end else if (idx_q >= IdxW'(20) && idx_q < IdxW'(28)) begin
					wide_d[1][8*3'(idx_q - IdxW'(20)) +: 8] = rx_byte;
				end else if (idx_q >= IdxW'(28) && idx_q < IdxW'(32)) begin
					narrow_d[2][8*idx_q[1:0] +: 8] = rx_byte;
				end else if (idx_q >= IdxW'(32)) begin
					if (flag_s && idx_q == IdxW'(32))
						stat_d[0] = rx_byte;
					if (flag_s && idx_q == IdxW'(33))
						stat_d[1] = rx_byte;
					// orientation words follow the status block when present
					if (narrow_q[0][FLAG_ORIENT_BIT] && idx_q >= obase
					    && idx_q < obase + IdxW'(12))
						narrow_d[3 + okey[3:2]][8*okey[1:0] +: 8] = rx_byte;
				end
				idx_d = idx_inc;
				if (16'(idx_inc) >= len_q) begin
					hit     = 1'b1;
					phase_d = PH_IDLE;
				end
			end
			PH_FBODY: begin
				if (idx_q >= IdxW'(FIXED_FRAME_LEN - 1)) begin
					hit        = (rx_byte == sum_q);
					kind_fixed = 1'b1;
					phase_d    = PH_IDLE;
				end else begin
					sum_d = sum_q - rx_byte;
					// three big-endian bytes per pose value from byte 2 on
					for (int g = 0; g < 6; g++) begin
						if (idx_q >= IdxW'(2 + 3*g) && idx_q < IdxW'(5 + 3*g))
							narrow_d[g] = {8'h00, narrow_q[g][15:0], rx_byte};
					end
					idx_d = idx_inc;
				end
			end
			default: begin
				if (cfg.mode != MODE_FIXED_ONLY && rx_byte == cfg.hdr_first) begin
					wide_d   = '{default: '0};
					narrow_d = '{default: '0};
					stat_d   = '{default: '0};
					idx_d    = IdxW'(1);
					phase_d  = PH_HDR2;
				end else if (cfg.mode != MODE_HDR_ONLY && rx_byte == cfg.fixed_id) begin
					wide_d   = '{default: '0};
					narrow_d = '{default: '0};
					stat_d   = '{default: '0};
					sum_d    = SUM_SEED - rx_byte;
					idx_d    = IdxW'(1);
					phase_d  = PH_FBODY;
				end else begin
					phase_d = PH_IDLE;
				end
			end
		endcase
	end

	// blocks cut off by the frame length read as absent
	assign off_end = flag_s ? 6'd48 : 6'd44;
	assign has_s   = narrow_d[0][FLAG_STATUS_BIT] && len_q >= 16'd36;
	assign has_o   = narrow_d[0][FLAG_ORIENT_BIT] && 16'(off_end) <= len_q;

	always_comb begin
		if (kind_fixed) begin
			res.frame_kind    = 1'b0;
			res.pos_x         = sx64(narrow_q[4]);
			res.pos_y         = sx64(narrow_q[5]);
			res.pos_z         = sx32(narrow_q[3]);
			res.roll          = sx32(narrow_q[2]);
			res.pitch         = sx32(narrow_q[0]);
			res.yaw           = sx32(narrow_q[1]);
			res.time_ms       = '0;
			res.flag_word     = '0;
			res.beacon_count  = '0;
			res.solution_type = '0;
		end else begin
			res.frame_kind    = 1'b1;
			res.pos_x         = wide_d[0];
			res.pos_y         = wide_d[1];
			res.pos_z         = narrow_d[2];
			res.roll          = has_o ? narrow_d[3] : '0;
			res.pitch         = has_o ? narrow_d[4] : '0;
			res.yaw           = has_o ? narrow_d[5] : '0;
			res.time_ms       = narrow_d[1];
			res.flag_word     = narrow_d[0];
			res.beacon_count  = has_s ? stat_d[0] : '0;
			res.solution_type = has_s ? stat_d[1] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q   <= '0;
			len_q   <= '0;
			sum_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			len_q   <= len_d;
			sum_q   <= sum_d;
		end
	end

	// captures are cleared at every frame start
	always_ff @(posedge clk) begin
		if (step) begin
			wide_q   <= wide_d;
			narrow_q <= narrow_d;
			stat_q   <= stat_d;
		end
	end

endmodule

// ----- src/tracking_frame_deframer.sv -----
// top level: config registers, input register, parser and output register
// a frame's last byte goes through the input register and parser to m_tvalid_q
// throughput: one byte per cycle unless stalled; parser takes the registered byte
// a held result stalls the input only when the next byte completes another frame
// arst_n clears the parser state and valid flags, config returns to reset values
module tracking_frame_deframer #(
	parameter int MAX_FRAME_LEN = 512,
	parameter int MIN_FRAME_LEN = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // rx_byte
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// pos_x, pos_y, pos_z, roll, pitch, yaw, time_ms, flag_word,
	// beacon_count, solution_type
	output logic [tfd_pkg::TDATA_W-1:0] m_tdata,
	output logic                        m_tuser,   // frame_kind
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [7:0]                  cfg_data
);
	import tfd_pkg::*;

	cfg_t             cfg_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             hit, stall, step;
	res_t             res;
	logic             m_tvalid_q;
	logic             m_tuser_q;
	logic [TDATA_W-1:0] m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode       <= '0;
			cfg_q.hdr_first  <= '0;
			cfg_q.hdr_second <= '0;
			cfg_q.fixed_id   <= FIXED_ID_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE:       cfg_q.mode       <= cfg_data[1:0];
				CFG_HDR_FIRST:  cfg_q.hdr_first  <= cfg_data;
				CFG_HDR_SECOND: cfg_q.hdr_second <= cfg_data;
				CFG_FIXED_ID:   cfg_q.fixed_id   <= cfg_data;
				default: ;
			endcase
		end
	end

	// only a byte that finishes a frame needs the output slot
	assign stall    = valid_s1 && hit && m_tvalid_q && !m_tready;
	assign step     = valid_s1 && !stall;
	assign s_tready = !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			byte_s1 <= s_tdata;
	end

	tfd_parser #(
		.MAX_FRAME_LEN(MAX_FRAME_LEN),
		.MIN_FRAME_LEN(MIN_FRAME_LEN)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.hit     (hit),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (step && hit)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step && hit) begin
			m_tuser_q <= res.frame_kind;
			m_tdata_q <= {res.solution_type, res.beacon_count, res.flag_word, res.time_ms,
				res.yaw, res.pitch, res.roll, res.pos_z, res.pos_y, res.pos_x};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ----- tb/tracking_frame_deframer_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench of the tracking frame deframer: directed frames, then random byte streams
module tracking_frame_deframer_tb;
	import tfd_pkg::*;

	localparam int MAX_LEN = 512;
	localparam int MIN_LEN = 32;
	localparam logic [1:0] MODE_BOTH     = 2'd0;
	localparam logic [1:0] MODE_BOTH_ALT = 2'd3;

	typedef enum logic [2:0] {
		PH_IDLE, PH_HDR2, PH_LEN_LO, PH_LEN_HI, PH_HBODY, PH_FBODY
	} parse_e;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata   = '0;
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tuser;
	logic               cfg_we    = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [7:0]         cfg_data  = '0;

	// register copies
	logic [1:0] mode_reg       = MODE_BOTH;
	logic [7:0] hdr_first_reg  = 8'h00;
	logic [7:0] hdr_second_reg = 8'h00;
	logic [7:0] fixed_id_reg   = FIXED_ID_RESET;

	// parser copy
	parse_e      prs_phase = PH_IDLE;
	int unsigned prs_index = 0;
	logic [15:0] prs_len   = '0;
	logic [7:0]  prs_sum   = '0;
	logic [63:0] cap_wide[2]   = '{default: '0};
	logic [31:0] cap_narrow[6] = '{default: '0};
	logic [7:0]  cap_status[2] = '{default: '0};

	res_t       expected_frames[$];
	logic [7:0] tx_bytes[$];
	int errors           = 0;
	int frames_predicted = 0;
	int frame_bytes      = 0;
	int idle_phase       = 0;
	int cyc              = 0;
	int hold_until       = 0;

	tracking_frame_deframer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	task automatic clear_captures();
		cap_wide   = '{default: '0};
		cap_narrow = '{default: '0};
		cap_status = '{default: '0};
	endtask

	task automatic put_byte(input logic [7:0] b);
		tx_bytes.insert(tx_bytes.size(), b);
	endtask

	task automatic put_frame(input res_t r);
		expected_frames.insert(expected_frames.size(), r);
	endtask

	// advance the parser copy by one received byte, queue the frame it completes
	task automatic deframe_byte(input logic [7:0] b);
		res_t        r;
		int unsigned g, k, obase;
		logic [31:0] flg;
		logic        has_s, has_o;
		flg = cap_narrow[0];
		case (prs_phase)
			PH_HDR2: begin
				if (b == hdr_second_reg) begin
					prs_index = 2;
					prs_phase = PH_LEN_LO;
				end else begin
					prs_phase = PH_IDLE;
				end
			end
			PH_LEN_LO: begin
				prs_len   = {8'h00, b};
				prs_index = 3;
				prs_phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				prs_len[15:8] = b;
				prs_index     = 4;
				prs_phase     = (prs_len < MIN_LEN || prs_len > MAX_LEN) ? PH_IDLE : PH_HBODY;
			end
			PH_HBODY: begin
				if (prs_index < 8)
					cap_narrow[0] |= 32'(b) << (8 * (prs_index - 4));
				else if (prs_index < 12)
					cap_narrow[1] |= 32'(b) << (8 * (prs_index - 8));
				else if (prs_index < 20)
					cap_wide[0] |= 64'(b) << (8 * (prs_index - 12));
				else if (prs_index < 28)
					cap_wide[1] |= 64'(b) << (8 * (prs_index - 20));
				else if (prs_index < 32)
					cap_narrow[2] |= 32'(b) << (8 * (prs_index - 28));
				else begin
					obase = flg[FLAG_STATUS_BIT] ? 36 : 32;
					if (flg[FLAG_STATUS_BIT] && prs_index == 32) cap_status[0] = b;
					if (flg[FLAG_STATUS_BIT] && prs_index == 33) cap_status[1] = b;
					if (flg[FLAG_ORIENT_BIT] && prs_index >= obase && prs_index < obase + 12) begin
						k = prs_index - obase;
						cap_narrow[3 + k / 4] |= 32'(b) << (8 * (k % 4));
					end
				end
				prs_index++;
				if (prs_index >= prs_len) begin
					flg   = cap_narrow[0];
					obase = flg[FLAG_STATUS_BIT] ? 36 : 32;
					// blocks cut off by the length read as absent
					has_s = flg[FLAG_STATUS_BIT] && prs_len >= 36;
					has_o = flg[FLAG_ORIENT_BIT] && obase + 12 <= prs_len;
					r               = '0;
					r.frame_kind    = 1'b1;
					r.pos_x         = cap_wide[0];
					r.pos_y         = cap_wide[1];
					r.pos_z         = cap_narrow[2];
					r.roll          = has_o ? cap_narrow[3] : 32'h0;
					r.pitch         = has_o ? cap_narrow[4] : 32'h0;
					r.yaw           = has_o ? cap_narrow[5] : 32'h0;
					r.time_ms       = cap_narrow[1];
					r.flag_word     = flg;
					r.beacon_count  = has_s ? cap_status[0] : 8'h0;
					r.solution_type = has_s ? cap_status[1] : 8'h0;
					put_frame(r);
					frames_predicted++;
					prs_phase = PH_IDLE;
				end
			end
			PH_FBODY: begin
				if (prs_index >= FIXED_FRAME_LEN - 1) begin
					if (b == prs_sum) begin
						r            = '0;
						r.frame_kind = 1'b0;
						r.pos_x      = {{40{cap_narrow[4][23]}}, cap_narrow[4][23:0]};
						r.pos_y      = {{40{cap_narrow[5][23]}}, cap_narrow[5][23:0]};
						r.pos_z      = {{8{cap_narrow[3][23]}}, cap_narrow[3][23:0]};
						r.roll       = {{8{cap_narrow[2][23]}}, cap_narrow[2][23:0]};
						r.pitch      = {{8{cap_narrow[0][23]}}, cap_narrow[0][23:0]};
						r.yaw        = {{8{cap_narrow[1][23]}}, cap_narrow[1][23:0]};
						put_frame(r);
						frames_predicted++;
					end
					prs_phase = PH_IDLE;
				end else begin
					prs_sum = prs_sum - b;
					if (prs_index >= 2 && prs_index < 20) begin
						g = (prs_index - 2) / 3;
						cap_narrow[g] = {8'h00, cap_narrow[g][15:0], b};
					end
					prs_index++;
				end
			end
			default: begin
				// headered frame wins when a byte could start either
				if (mode_reg != MODE_FIXED_ONLY && b == hdr_first_reg) begin
					clear_captures();
					prs_index = 1;
					prs_phase = PH_HDR2;
				end else if (mode_reg != MODE_HDR_ONLY && b == fixed_id_reg) begin
					clear_captures();
					prs_sum   = SUM_SEED - b;
					prs_index = 1;
					prs_phase = PH_FBODY;
				end else begin
					prs_phase = PH_IDLE;
				end
			end
		endcase
	endtask

	task automatic send_byte(input logic [7:0] b);
		int pct;
		pct = (idle_phase == 0) ? 18 : (idle_phase == 1) ? 78 : 0;
		if ($urandom_range(99) < pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		deframe_byte(b);
	endtask

	task automatic transmit(input int n);
		logic [7:0] b;
		for (int i = 0; i < n && tx_bytes.size() != 0; i++) begin
			b = tx_bytes[0];
			tx_bytes.delete(0);
			frame_bytes++;
			send_byte(b);
		end
	endtask

	// drop valid, wait for every outstanding frame and let the pipeline drain
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_MODE:       mode_reg       = val[1:0];
			CFG_HDR_FIRST:  hdr_first_reg  = val;
			CFG_HDR_SECOND: hdr_second_reg = val;
			CFG_FIXED_ID:   fixed_id_reg   = val;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [1:0] md, input logic [7:0] h1, input logic [7:0] h2,
		input logic [7:0] fid);
		cfg_write(CFG_MODE, {6'd0, md});
		cfg_write(CFG_HDR_FIRST, h1);
		cfg_write(CFG_HDR_SECOND, h2);
		cfg_write(CFG_FIXED_ID, fid);
	endtask

	// pose order: pitch, yaw, roll, z, x, y
	task automatic queue_fixed(input logic [5:0][23:0] v, input bit bad_sum);
		logic [7:0] fr[29];
		logic [7:0] sum;
		sum   = '0;
		fr[0] = fixed_id_reg;
		fr[1] = 8'($urandom);
		for (int g = 0; g < 6; g++) begin
			fr[2 + 3 * g] = v[g][23:16];
			fr[3 + 3 * g] = v[g][15:8];
			fr[4 + 3 * g] = v[g][7:0];
		end
		for (int i = 20; i < 28; i++) fr[i] = 8'($urandom);
		for (int i = 0; i < 28; i++) sum += fr[i];
		fr[28] = SUM_SEED - sum;
		if (bad_sum) fr[28] ^= 8'($urandom_range(255, 1));
		foreach (fr[i]) put_byte(fr[i]);
	endtask

	// nbytes below len leaves the frame open
	task automatic queue_headered(input logic [15:0] len, input logic [31:0] flags,
		input int nbytes);
		logic [7:0] b;
		for (int i = 0; i < nbytes; i++) begin
			if (i == 0)      b = hdr_first_reg;
			else if (i == 1) b = hdr_second_reg;
			else if (i == 2) b = len[7:0];
			else if (i == 3) b = len[15:8];
			else if (i < 8)  b = flags[8 * (i - 4) +: 8];
			else             b = 8'($urandom);
			put_byte(b);
		end
	endtask

	function automatic logic [5:0][23:0] rand_pose();
		logic [5:0][23:0] v;
		for (int g = 0; g < 6; g++) begin
			case ($urandom_range(9))
				0:       v[g] = 24'h7FFFFF;
				1:       v[g] = 24'h800000;
				2:       v[g] = $urandom_range(1) ? 24'h000000 : 24'hFFFFFF;
				default: v[g] = 24'($urandom);
			endcase
		end
		return v;
	endfunction

	function automatic logic [15:0] rand_len();
		int p;
		p = $urandom_range(99);
		if (p < 60) return 16'($urandom_range(60, 32));
		if (p < 85) begin
			// lengths right at the status and orientation block edges
			case ($urandom_range(6))
				0: return 16'd32;
				1: return 16'd35;
				2: return 16'd36;
				3: return 16'd43;
				4: return 16'd44;
				5: return 16'd47;
				default: return 16'd48;
			endcase
		end
		if (p < 98) return 16'($urandom_range(120, 61));
		return 16'($urandom_range(512, 256));
	endfunction

	task automatic compare_field(input string nm, input logic [63:0] want_v,
		input logic [63:0] got_v);
		if (want_v !== got_v) begin
			errors++;
			$display("%0t mismatch %s: expected %h actual %h", $time, nm, want_v, got_v);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.frame_kind    = m_tuser;
			got.pos_x         = m_tdata[63:0];
			got.pos_y         = m_tdata[127:64];
			got.pos_z         = m_tdata[159:128];
			got.roll          = m_tdata[191:160];
			got.pitch         = m_tdata[223:192];
			got.yaw           = m_tdata[255:224];
			got.time_ms       = m_tdata[287:256];
			got.flag_word     = m_tdata[319:288];
			got.beacon_count  = m_tdata[327:320];
			got.solution_type = m_tdata[335:328];
			if (expected_frames.size() == 0) begin
				errors++;
				$display("%0t unexpected frame: expected none, actual kind %0d data %h",
					$time, m_tuser, m_tdata);
			end else begin
				want = expected_frames[0];
				expected_frames.delete(0);
				compare_field("frame_kind", 64'(want.frame_kind), 64'(got.frame_kind));
				compare_field("pos_x", want.pos_x, got.pos_x);
				compare_field("pos_y", want.pos_y, got.pos_y);
				compare_field("pos_z", 64'(want.pos_z), 64'(got.pos_z));
				compare_field("roll", 64'(want.roll), 64'(got.roll));
				compare_field("pitch", 64'(want.pitch), 64'(got.pitch));
				compare_field("yaw", 64'(want.yaw), 64'(got.yaw));
				compare_field("time_ms", 64'(want.time_ms), 64'(got.time_ms));
				compare_field("flag_word", 64'(want.flag_word), 64'(got.flag_word));
				compare_field("beacon_count", 64'(want.beacon_count),
					64'(got.beacon_count));
				compare_field("solution_type", 64'(want.solution_type),
					64'(got.solution_type));
			end
		end
	end

	// output ready: random stalls plus a counted hold-off window
	always @(posedge clk) begin
		int pct;
		cyc++;
		pct = (idle_phase == 0) ? 78 : (idle_phase == 1) ? 18 : 0;
		if (cyc < hold_until) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= pct);
		end
	end

	task automatic test_reset_config();
		idle_phase = 0;
		queue_fixed({24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF, 24'h000001, 24'hABCDEF}, 0);
		queue_headered(16'd32, 32'h0000_0000, 32);
		transmit(tx_bytes.size());
		settle();
	endtask

	task automatic test_fixed_frames();
		set_config(MODE_FIXED_ONLY, 8'hFF, 8'hFF, 8'h00);
		queue_fixed({6{24'h7FFFFF}}, 0);
		queue_fixed({6{24'h800000}}, 0);
		queue_fixed({6{24'h000000}}, 0);
		queue_fixed({6{24'hFFFFFF}}, 0);
		queue_fixed(rand_pose(), 0);
		queue_fixed(rand_pose(), 1);
		transmit(tx_bytes.size());
		settle();
		set_config(MODE_BOTH, 8'h00, 8'h00, 8'hFF);
		queue_fixed(rand_pose(), 0);
		transmit(tx_bytes.size());
		settle();
	endtask

	task automatic test_headered_frames();
		set_config(MODE_HDR_ONLY, 8'hFF, 8'h00, 8'h55);
		queue_headered(16'd32, 32'hFFFF_FFF9, 32);
		queue_headered(16'd36, 32'h0000_0002, 36);
		queue_headered(16'd35, 32'h0000_0002, 35);
		queue_headered(16'd44, 32'h0000_0004, 44);
		queue_headered(16'd43, 32'h0000_0004, 43);
		queue_headered(16'd48, 32'h0000_0006, 48);
		queue_headered(16'd47, 32'hFFFF_FFFF, 47);
		queue_headered(16'd512, 32'h8000_0006, 512);
		// lengths out of range end the frame at once
		queue_headered(16'd31, 32'h0, 4);
		queue_headered(16'd513, 32'h0, 4);
		queue_headered(16'hFFFF, 32'h0, 4);
		// wrong second header byte
		put_byte(8'hFF);
		put_byte(8'h01);
		queue_headered(16'd40, 32'h0000_0006, 40);
		// fixed frames are not looked for in this mode
		queue_fixed({6{24'h123456}}, 0);
		transmit(tx_bytes.size());
		settle();
	endtask

	task automatic test_special_cases();
		// same byte starts both frame types: headered wins
		set_config(MODE_BOTH_ALT, 8'hA5, 8'h5A, 8'hA5);
		queue_headered(16'd48, 32'h0000_0006, 48);
		transmit(tx_bytes.size());
		settle();
		set_config(MODE_FIXED_ONLY, 8'hA5, 8'h5A, 8'hA5);
		queue_fixed(rand_pose(), 0);
		transmit(tx_bytes.size());
		settle();
		// byte after a failed header is not a frame start even if it matches the id
		set_config(MODE_BOTH, 8'hA5, 8'h5A, 8'h3C);
		put_byte(8'hA5);
		put_byte(8'h3C);
		queue_fixed(rand_pose(), 0);
		// hunting resumes right after a bad checksum
		queue_fixed(rand_pose(), 1);
		queue_fixed(rand_pose(), 0);
		transmit(tx_bytes.size());
		settle();
		// id change with a fixed frame half received
		queue_fixed(rand_pose(), 0);
		transmit(12);
		settle();
		cfg_write(CFG_FIXED_ID, 8'h00);
		transmit(tx_bytes.size());
		settle();
	endtask

	task automatic test_backpressure();
		idle_phase = 2;
		set_config(MODE_BOTH, 8'h7E, 8'h81, FIXED_ID_RESET);
		hold_until = cyc + 600;
		repeat (4) queue_fixed(rand_pose(), 0);
		transmit(tx_bytes.size());
		settle();
		repeat (2) begin
			queue_headered(16'd48, 32'h0000_0006, 48);
			queue_fixed(rand_pose(), 0);
		end
		transmit(tx_bytes.size());
		settle();
	endtask

	task automatic test_random_traffic(input int phase);
		int          start_bytes, start_frames, pick;
		logic [15:0] len;
		logic [7:0]  b;
		idle_phase = phase;
		set_config(2'($urandom_range(3)), 8'($urandom), 8'($urandom), 8'($urandom));
		start_bytes  = frame_bytes;
		start_frames = frames_predicted;
		for (int n = 0; n < 4000 && (frame_bytes - start_bytes < 50 ||
			frames_predicted - start_frames < 1); n++) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				queue_fixed(rand_pose(), 0);
			end else if (pick < 70) begin
				len = rand_len();
				queue_headered(len, $urandom, int'(len));
			end else if (pick < 78) begin
				queue_fixed(rand_pose(), 1);
			end else if (pick < 83) begin
				b = 8'($urandom);
				while (b == hdr_second_reg) b = 8'($urandom);
				put_byte(hdr_first_reg);
				put_byte(b);
			end else if (pick < 88) begin
				len = $urandom_range(1) ? 16'($urandom_range(31)) :
					16'($urandom_range(65535, 513));
				queue_headered(len, $urandom, 4);
			end else if (pick < 94) begin
				len = rand_len();
				queue_headered(len, $urandom, $urandom_range(len - 1, 1));
			end else begin
				repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
			end
			transmit(tx_bytes.size());
		end
		settle();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_fixed_frames();
		test_headered_frames();
		test_special_cases();
		test_backpressure();
		test_random_traffic(0);
		test_random_traffic(1);
		test_random_traffic(2);
		for (int n = 0; n < 20000 && expected_frames.size() != 0; n++) @(posedge clk);
		repeat (16) @(posedge clk);
		if (expected_frames.size() != 0)
			$display("%0t %0d expected frames never arrived", $time, expected_frames.size());
		if (errors == 0 && expected_frames.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("%0t timeout", $time);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
